// File: sv/scan_line_segment_extractor_core_assert.svh
// Assertion macros for the scan line segment extractor.
// Used by the top level; no other dependencies.
`ifndef SCAN_LINE_SEGMENT_EXTRACTOR_CORE_ASSERT_SVH
`define SCAN_LINE_SEGMENT_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SLSE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define SLSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/slse_pkg.sv
// Shared types and constants of the scan line segment extractor.
// No dependencies; imported by the controller, datapath and top level.
package slse_pkg;

   localparam int SLOPE_W = 32;
   localparam int ICPT_W  = 40;
   localparam int LEN_W   = 24;
   localparam int CSR_W   = 16;
   localparam int IDX_W   = 8;
   localparam int CNT_W   = 16;

   localparam logic [SLOPE_W-1:0] SLOPE_SAT = 32'h7FFF_FFFF;
   localparam logic [LEN_W-1:0]   LEN_MAX   = 24'hFF_FFFF;
   localparam logic [CNT_W-1:0]   COUNT_MAX = 16'hFFFF;

   // Configuration register indexes
   localparam logic [IDX_W-1:0] REG_BAND_TOL   = 8'd0;
   localparam logic [IDX_W-1:0] REG_GAP_LIMIT  = 8'd1;
   localparam logic [IDX_W-1:0] REG_MIN_LENGTH = 8'd2;
   localparam logic [IDX_W-1:0] REG_MIN_POINTS = 8'd3;

   // Datapath operations
   typedef logic [4:0] op_type;
   localparam op_type OP_NOP         = 5'd0;
   localparam op_type OP_FIRST       = 5'd1;
   localparam op_type OP_SQX         = 5'd2;
   localparam op_type OP_SQY         = 5'd3;
   localparam op_type OP_LIM         = 5'd4;
   localparam op_type OP_BAND_M      = 5'd5;
   localparam op_type OP_BAND_R      = 5'd6;
   localparam op_type OP_DIV_SLOPE   = 5'd7;
   localparam op_type OP_DIV_AVG     = 5'd8;
   localparam op_type OP_SET_SLOPE   = 5'd9;
   localparam op_type OP_NEW_SLOPE   = 5'd10;
   localparam op_type OP_AVG_UPD     = 5'd11;
   localparam op_type OP_ANCHOR_P    = 5'd12;
   localparam op_type OP_ANCHOR_PREV = 5'd13;
   localparam op_type OP_SQRT_START  = 5'd14;
   localparam op_type OP_ICPT_M      = 5'd15;
   localparam op_type OP_ICPT        = 5'd16;
   localparam op_type OP_EMIT        = 5'd17;

   typedef struct packed {
      op_type op;
      logic   base_prev;  // difference base: previous point instead of anchor
      logic   pt_prev;    // difference point: previous point instead of request
   } cmd_type;

   typedef struct packed {
      logic far;
      logic band_ok;
      logic elig;
      logic div_busy;
      logic sqrt_busy;
      logic out_full;
      logic last;
   } status_type;

endpackage

// File: sv/slse_datapath.sv
// Datapath: point state, shared multiplier, serial divider, serial square root
// and result register. Depends on slse_pkg; driven by slse_controller commands.
module slse_datapath #(
   parameter int COORD_BITS      = 24,
   parameter int SLOPE_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load_en,
   input  logic signed [COORD_BITS-1:0]         x_in,
   input  logic signed [COORD_BITS-1:0]         y_in,
   input  logic                                 last_in,
   input  logic                                 csr_write_enable,
   input  logic [slse_pkg::IDX_W-1:0]           csr_index,
   input  logic [slse_pkg::CSR_W-1:0]           csr_write_data,
   input  slse_pkg::cmd_type                    cmd,
   output slse_pkg::status_type                 status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [slse_pkg::SLOPE_W-1:0]  rsp_line_slope,
   output logic signed [slse_pkg::ICPT_W-1:0]   rsp_line_intercept,
   output logic [slse_pkg::LEN_W-1:0]           rsp_line_length
);
   import slse_pkg::*;

   localparam int F     = SLOPE_FRAC_BITS;
   localparam int D     = COORD_BITS + 1;
   localparam int AW    = (D > SLOPE_W) ? D : SLOPE_W;
   localparam int PW    = AW + D;
   localparam int ACW   = PW + 2;
   localparam int NUMW  = D + F + 1;
   localparam int DW    = (NUMW > 34) ? NUMW : 34;
   localparam int DENW  = (D > CNT_W) ? D : CNT_W;
   localparam int DCW   = $clog2(DW);
   localparam int SQW   = ACW + (ACW % 2);
   localparam int RW    = SQW / 2;
   localparam int RCW   = $clog2(RW);
   localparam int MW    = ACW + 2;

   // Configuration registers
   logic [15:0] band_ff, gap_ff, minlen_ff;
   logic [7:0]  minpts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff   <= 16'd102;
         gap_ff    <= 16'd307;
         minlen_ff <= 16'd256;
         minpts_ff <= 8'd3;
      end else if (csr_write_enable) begin
         priority case (csr_index)
            REG_BAND_TOL:   band_ff   <= csr_write_data;
            REG_GAP_LIMIT:  gap_ff    <= csr_write_data;
            REG_MIN_LENGTH: minlen_ff <= csr_write_data;
            REG_MIN_POINTS: minpts_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // Point and segment state
   logic signed [COORD_BITS-1:0] px_ff, py_ff, ax_ff, ay_ff, prx_ff, pry_ff;
   logic                         last_ff;
   logic signed [SLOPE_W-1:0]    slope_ff, nslope_ff;
   logic [CNT_W-1:0]             count_ff;
   logic signed [ACW-1:0]        acc_ff;
   logic [47:0]                  lim_ff;
   logic signed [ICPT_W-1:0]     icpt_ff;

   // Differences for the selected base and point
   logic signed [COORD_BITS-1:0] base_x, base_y, pt_x, pt_y;
   logic signed [D-1:0]          dx, dy;
   logic [D-1:0]                 dx_mag, dy_mag;

   always_comb begin
      base_x = cmd.base_prev ? prx_ff : ax_ff;
      base_y = cmd.base_prev ? pry_ff : ay_ff;
      pt_x   = cmd.pt_prev ? prx_ff : px_ff;
      pt_y   = cmd.pt_prev ? pry_ff : py_ff;
      dx     = D'(pt_x) - D'(base_x);
      dy     = D'(pt_y) - D'(base_y);
      dx_mag = dx[D-1] ? D'(-dx) : D'(dx);
      dy_mag = dy[D-1] ? D'(-dy) : D'(dy);
   end

   // Shared multiplier
   logic [SLOPE_W-1:0]    slope_mag, lim_sel, one_val;
   logic signed [AW-1:0]  mul_a;
   logic signed [D-1:0]   mul_b;
   logic signed [PW-1:0]  prod;

   always_comb begin
      one_val   = SLOPE_W'(1) << F;
      slope_mag = slope_ff[SLOPE_W-1] ? SLOPE_W'(-slope_ff) : SLOPE_W'(slope_ff);
      lim_sel   = (slope_mag > one_val) ? slope_mag : one_val;
      mul_a = '0;
      mul_b = '0;
      priority case (cmd.op)
         OP_SQX: begin
            mul_a = AW'(dx);
            mul_b = dx;
         end
         OP_SQY: begin
            mul_a = AW'(dy);
            mul_b = dy;
         end
         OP_BAND_M: begin
            mul_a = AW'(slope_ff);
            mul_b = dx;
         end
         OP_LIM: begin
            mul_a = AW'($signed({1'b0, lim_sel}));
            mul_b = D'($signed({1'b0, band_ff}));
         end
         OP_ICPT_M: begin
            mul_a = AW'(slope_ff);
            mul_b = D'(ax_ff);
         end
         default: ;
      endcase
   end
   assign prod = PW'(mul_a) * PW'(mul_b);

   // Serial restoring divider
   logic [DW-1:0]     dnum_ff;
   logic [DENW-1:0]   drem_ff, dden_ff;
   logic [DCW-1:0]    dcnt_ff;
   logic              dbusy_ff, dneg_ff;
   logic [DENW:0]     rem_sh;
   logic              qbit;
   logic signed [SLOPE_W:0] diff;
   logic [SLOPE_W:0]  diff_mag;
   logic [CNT_W-1:0]  n_val;

   always_comb begin
      diff     = (SLOPE_W+1)'(nslope_ff) - (SLOPE_W+1)'(slope_ff);
      diff_mag = diff[SLOPE_W] ? (SLOPE_W+1)'(-diff) : (SLOPE_W+1)'(diff);
      n_val    = (count_ff == '0) ? CNT_W'(1) : count_ff;
      rem_sh   = {drem_ff, dnum_ff[DW-1]};
      qbit     = (rem_sh >= {1'b0, dden_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (cmd.op == OP_DIV_SLOPE || cmd.op == OP_DIV_AVG) begin
         dbusy_ff <= 1'b1;
      end else if (dbusy_ff && dcnt_ff == '0) begin
         dbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_DIV_SLOPE) begin
         dnum_ff <= (DW'(dy_mag) << F) + DW'(dx_mag >> 1);
         dden_ff <= DENW'(dx_mag);
         drem_ff <= '0;
         dneg_ff <= dx[D-1] != dy[D-1];
         dcnt_ff <= DCW'(DW - 1);
      end else if (cmd.op == OP_DIV_AVG) begin
         dnum_ff <= DW'(diff_mag) + DW'(n_val >> 1);
         dden_ff <= DENW'(n_val);
         drem_ff <= '0;
         dneg_ff <= diff[SLOPE_W];
         dcnt_ff <= DCW'(DW - 1);
      end else if (dbusy_ff) begin
         drem_ff <= qbit ? DENW'(rem_sh - {1'b0, dden_ff}) : DENW'(rem_sh);
         dnum_ff <= {dnum_ff[DW-2:0], qbit};
         dcnt_ff <= dcnt_ff - DCW'(1);
      end
   end

   // Slope of the request point against the anchor
   logic [SLOPE_W-1:0]        q_sat;
   logic signed [SLOPE_W-1:0] slope_res;

   always_comb begin
      q_sat = (dnum_ff > DW'(SLOPE_SAT)) ? SLOPE_SAT : dnum_ff[SLOPE_W-1:0];
      if (dx == '0) begin
         if (dy == '0)         slope_res = '0;
         else if (dy[D-1])     slope_res = -$signed(SLOPE_SAT);
         else                  slope_res = $signed(SLOPE_SAT);
      end else begin
         slope_res = dneg_ff ? -$signed(q_sat) : $signed(q_sat);
      end
   end

   // Weighted slope update
   logic signed [SLOPE_W+1:0] avg_q, avg_sum;

   always_comb begin
      avg_q   = $signed({1'b0, dnum_ff[SLOPE_W:0]});
      avg_sum = (SLOPE_W+2)'(slope_ff) + (dneg_ff ? -avg_q : avg_q);
   end

   // Serial square root
   logic [SQW-1:0]  rad_ff;
   logic [RW-1:0]   root_ff;
   logic [RW+1:0]   srem_ff;
   logic [RCW-1:0]  scnt_ff;
   logic            sbusy_ff;
   logic [RW+3:0]   srem_sh, strial;
   logic            sbit;

   always_comb begin
      srem_sh = {srem_ff, rad_ff[SQW-1:SQW-2]};
      strial  = (RW+4)'({root_ff, 2'b01});
      sbit    = (srem_sh >= strial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sbusy_ff <= 1'b0;
      end else if (cmd.op == OP_SQRT_START) begin
         sbusy_ff <= 1'b1;
      end else if (sbusy_ff && scnt_ff == '0) begin
         sbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_SQRT_START) begin
         rad_ff  <= SQW'($unsigned(acc_ff));
         root_ff <= '0;
         srem_ff <= '0;
         scnt_ff <= RCW'(RW - 1);
      end else if (sbusy_ff) begin
         srem_ff <= sbit ? (RW+2)'(srem_sh - strial) : (RW+2)'(srem_sh);
         root_ff <= {root_ff[RW-2:0], sbit};
         rad_ff  <= rad_ff << 2;
         scnt_ff <= scnt_ff - RCW'(1);
      end
   end

   // Intercept: anchor_y minus rounded slope times anchor_x, saturated
   logic [ACW-1:0]         acc_mag;
   logic [ACW:0]           icpt_q;
   logic signed [MW-1:0]   icpt_m;
   logic signed [ICPT_W-1:0] icpt_res;

   always_comb begin
      acc_mag = acc_ff[ACW-1] ? ACW'(-acc_ff) : ACW'(acc_ff);
      icpt_q  = ((ACW+1)'(acc_mag) + ((ACW+1)'(1) << (F - 1))) >> F;
      icpt_m  = MW'(ay_ff) - (acc_ff[ACW-1] ? -$signed(MW'(icpt_q)) : $signed(MW'(icpt_q)));
      if (icpt_m > $signed(MW'({1'b0, {(ICPT_W-1){1'b1}}})))
         icpt_res = {1'b0, {(ICPT_W-1){1'b1}}};
      else if (icpt_m < -$signed(MW'({1'b1, {(ICPT_W-1){1'b0}}})))
         icpt_res = {1'b1, {(ICPT_W-1){1'b0}}};
      else
         icpt_res = icpt_m[ICPT_W-1:0];
   end

   // State updates per command
   always_ff @(posedge clock) begin
      if (load_en) begin
         px_ff   <= x_in;
         py_ff   <= y_in;
         last_ff <= last_in;
      end
      priority case (cmd.op)
         OP_FIRST: begin
            ax_ff  <= px_ff;
            ay_ff  <= py_ff;
            prx_ff <= px_ff;
            pry_ff <= py_ff;
         end
         OP_SQX:    acc_ff <= ACW'(prod);
         OP_SQY:    acc_ff <= acc_ff + ACW'(prod);
         OP_BAND_M: acc_ff <= ACW'(prod);
         OP_BAND_R: acc_ff <= (ACW'(dy) <<< F) - acc_ff;
         OP_ICPT_M: acc_ff <= ACW'(prod);
         OP_LIM:    lim_ff <= prod[47:0];
         OP_SET_SLOPE: begin
            slope_ff <= slope_res;
            prx_ff   <= px_ff;
            pry_ff   <= py_ff;
            count_ff <= CNT_W'(2);
         end
         OP_NEW_SLOPE: nslope_ff <= slope_res;
         OP_AVG_UPD: begin
            slope_ff <= avg_sum[SLOPE_W-1:0];
            prx_ff   <= px_ff;
            pry_ff   <= py_ff;
            if (count_ff != COUNT_MAX) count_ff <= count_ff + CNT_W'(1);
         end
         OP_ANCHOR_P: begin
            ax_ff <= px_ff;
            ay_ff <= py_ff;
         end
         OP_ANCHOR_PREV: begin
            ax_ff <= prx_ff;
            ay_ff <= pry_ff;
         end
         OP_ICPT: icpt_ff <= icpt_res;
         default: ;
      endcase
   end

   // Result register
   logic                      rvalid_ff;
   logic signed [SLOPE_W-1:0] rslope_ff;
   logic signed [ICPT_W-1:0]  ricpt_ff;
   logic [LEN_W-1:0]          rlen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rvalid_ff <= 1'b1;
      end else if (rvalid_ff && !rsp_stall) begin
         rvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         rslope_ff <= slope_ff;
         ricpt_ff  <= icpt_ff;
         rlen_ff   <= (root_ff > RW'(LEN_MAX)) ? LEN_MAX : root_ff[LEN_W-1:0];
      end
   end

   assign rsp_valid          = rvalid_ff;
   assign rsp_line_slope     = rslope_ff;
   assign rsp_line_intercept = ricpt_ff;
   assign rsp_line_length    = rlen_ff;

   // Status toward the controller
   logic [31:0] gap_sq, minlen_sq;

   always_comb begin
      gap_sq           = 32'(gap_ff) * 32'(gap_ff);
      minlen_sq        = 32'(minlen_ff) * 32'(minlen_ff);
      status.far       = acc_ff > $signed(ACW'(gap_sq));
      status.band_ok   = acc_mag <= ACW'(lim_ff);
      status.elig      = (acc_ff > $signed(ACW'(minlen_sq))) &&
                         (count_ff > CNT_W'(minpts_ff));
      status.div_busy  = dbusy_ff;
      status.sqrt_busy = sbusy_ff;
      status.out_full  = rvalid_ff;
      status.last      = last_ff;
   end

endmodule

// File: sv/slse_controller.sv
// Controller: segment phase and the command sequence for one request.
// Depends on slse_pkg; drives slse_datapath through cmd_type / status_type.
module slse_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  slse_pkg::status_type  status,
   output slse_pkg::cmd_type     cmd,
   output logic                  busy
);
   import slse_pkg::*;

   localparam logic [1:0] PH_EMPTY  = 2'd0;
   localparam logic [1:0] PH_ANCHOR = 2'd1;
   localparam logic [1:0] PH_OPEN   = 2'd2;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DISPATCH = 5'd1;
   localparam logic [4:0] S_TS_SQX   = 5'd2;
   localparam logic [4:0] S_TS_SQY   = 5'd3;
   localparam logic [4:0] S_TS_CHK   = 5'd4;
   localparam logic [4:0] S_TS_WAIT  = 5'd5;
   localparam logic [4:0] S_G_SQX    = 5'd6;
   localparam logic [4:0] S_G_SQY    = 5'd7;
   localparam logic [4:0] S_G_CHK    = 5'd8;
   localparam logic [4:0] S_B_MUL    = 5'd9;
   localparam logic [4:0] S_B_R      = 5'd10;
   localparam logic [4:0] S_B_CHK    = 5'd11;
   localparam logic [4:0] S_A_WAIT   = 5'd12;
   localparam logic [4:0] S_A_DIV2   = 5'd13;
   localparam logic [4:0] S_A_WAIT2  = 5'd14;
   localparam logic [4:0] S_CL_SQX   = 5'd15;
   localparam logic [4:0] S_CL_SQY   = 5'd16;
   localparam logic [4:0] S_CL_CHK   = 5'd17;
   localparam logic [4:0] S_CL_MUL   = 5'd18;
   localparam logic [4:0] S_CL_ICPT  = 5'd19;
   localparam logic [4:0] S_CL_WAIT  = 5'd20;
   localparam logic [4:0] S_CL_NEXT  = 5'd21;
   localparam logic [4:0] S_FINISH   = 5'd22;

   logic [4:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       brk_ff, brk_in;
   logic       emitted_ff, emitted_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= PH_EMPTY;
         brk_ff     <= 1'b0;
         emitted_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         brk_ff     <= brk_in;
         emitted_ff <= emitted_in;
      end
   end

   // Next state and command
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      brk_in        = brk_ff;
      emitted_in    = emitted_ff;
      cmd.op        = OP_NOP;
      cmd.base_prev = 1'b0;
      cmd.pt_prev   = 1'b0;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_DISPATCH;
         S_DISPATCH: begin
            emitted_in = 1'b0;
            unique case (phase_ff)
               PH_EMPTY: begin
                  cmd.op   = OP_FIRST;
                  phase_in = PH_ANCHOR;
                  state_in = S_FINISH;
               end
               PH_ANCHOR: state_in = S_TS_SQX;
               default:   state_in = S_G_SQX;
            endcase
         end
         // Start a segment from the anchor
         S_TS_SQX: begin
            cmd.op   = OP_SQX;
            state_in = S_TS_SQY;
         end
         S_TS_SQY: begin
            cmd.op   = OP_SQY;
            state_in = S_TS_CHK;
         end
         S_TS_CHK: begin
            if (status.far) begin
               cmd.op   = OP_ANCHOR_P;
               phase_in = PH_ANCHOR;
               state_in = S_FINISH;
            end else begin
               cmd.op   = OP_DIV_SLOPE;
               state_in = S_TS_WAIT;
            end
         end
         S_TS_WAIT: begin
            if (!status.div_busy) begin
               cmd.op   = OP_SET_SLOPE;
               phase_in = PH_OPEN;
               state_in = S_FINISH;
            end
         end
         // Gap test against the previous point
         S_G_SQX: begin
            cmd.op        = OP_SQX;
            cmd.base_prev = 1'b1;
            state_in      = S_G_SQY;
         end
         S_G_SQY: begin
            cmd.op        = OP_SQY;
            cmd.base_prev = 1'b1;
            state_in      = S_G_CHK;
         end
         S_G_CHK: begin
            if (status.far) begin
               brk_in   = 1'b1;
               state_in = S_CL_SQX;
            end else begin
               cmd.op   = OP_LIM;
               state_in = S_B_MUL;
            end
         end
         // Band test against the anchor
         S_B_MUL: begin
            cmd.op   = OP_BAND_M;
            state_in = S_B_R;
         end
         S_B_R: begin
            cmd.op   = OP_BAND_R;
            state_in = S_B_CHK;
         end
         S_B_CHK: begin
            if (!status.band_ok) begin
               brk_in   = 1'b1;
               state_in = S_CL_SQX;
            end else begin
               cmd.op   = OP_DIV_SLOPE;
               state_in = S_A_WAIT;
            end
         end
         // Point joins: fold its slope into the running average
         S_A_WAIT: begin
            if (!status.div_busy) begin
               cmd.op   = OP_NEW_SLOPE;
               state_in = S_A_DIV2;
            end
         end
         S_A_DIV2: begin
            cmd.op   = OP_DIV_AVG;
            state_in = S_A_WAIT2;
         end
         S_A_WAIT2: begin
            if (!status.div_busy) begin
               cmd.op   = OP_AVG_UPD;
               state_in = S_FINISH;
            end
         end
         // Close the open segment, emit when long enough
         S_CL_SQX: begin
            cmd.op      = OP_SQX;
            cmd.pt_prev = 1'b1;
            state_in    = S_CL_SQY;
         end
         S_CL_SQY: begin
            cmd.op      = OP_SQY;
            cmd.pt_prev = 1'b1;
            state_in    = S_CL_CHK;
         end
         S_CL_CHK: begin
            if (status.elig) begin
               cmd.op   = OP_SQRT_START;
               state_in = S_CL_MUL;
            end else begin
               state_in = S_CL_NEXT;
            end
         end
         S_CL_MUL: begin
            cmd.op   = OP_ICPT_M;
            state_in = S_CL_ICPT;
         end
         S_CL_ICPT: begin
            cmd.op   = OP_ICPT;
            state_in = S_CL_WAIT;
         end
         S_CL_WAIT: begin
            if (!status.sqrt_busy && !status.out_full) begin
               cmd.op     = OP_EMIT;
               emitted_in = 1'b1;
               state_in   = S_CL_NEXT;
            end
         end
         S_CL_NEXT: begin
            if (brk_ff) begin
               // previous point anchors; retry the breaking point
               brk_in   = 1'b0;
               cmd.op   = OP_ANCHOR_PREV;
               phase_in = PH_ANCHOR;
               state_in = S_TS_SQX;
            end else begin
               phase_in = PH_EMPTY;
               state_in = S_IDLE;
            end
         end
         S_FINISH: begin
            if (status.last) begin
               if (phase_ff == PH_OPEN && !emitted_ff) begin
                  state_in = S_CL_SQX;
               end else begin
                  phase_in = PH_EMPTY;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: sv/scan_line_segment_extractor_core.sv
// Scan line segment extractor. Takes one scan point per request and emits a
// segment (slope, intercept, length) when a segment closes long enough. One
// request is worked at a time; req_stall stays high until it is finished.
// The first point of a scan only sets the anchor and the previous point. A point
// that joins a segment makes two passes through the divider, which yields one
// quotient bit per cycle. When a segment closes with a result, most of the work
// is the serial square root. The longest case is a final point that joins and
// then closes with a result; it also waits while the previous result is still
// held by rsp_stall. A result waits in its own register, so the next request is
// taken while rsp_stall is held; only a second result waits for the first to
// leave.
`include "scan_line_segment_extractor_core_assert.svh"
module scan_line_segment_extractor_core #(
   parameter int COORD_BITS      = 24,
   parameter int SLOPE_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_BITS-1:0]         req_x_coord,
   input  logic signed [COORD_BITS-1:0]         req_y_coord,
   input  logic                                 req_last_point,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [slse_pkg::SLOPE_W-1:0]  rsp_line_slope,
   output logic signed [slse_pkg::ICPT_W-1:0]   rsp_line_intercept,
   output logic [slse_pkg::LEN_W-1:0]           rsp_line_length,
   input  logic                                 csr_write_enable,
   input  logic [slse_pkg::IDX_W-1:0]           csr_index,
   input  logic [slse_pkg::CSR_W-1:0]           csr_write_data
);
   import slse_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       busy;
   logic       accept;

   assign accept    = req_valid && !busy;
   assign req_stall = busy;

   slse_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   slse_datapath #(
      .COORD_BITS      (COORD_BITS),
      .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .load_en            (accept),
      .x_in               (req_x_coord),
      .y_in               (req_y_coord),
      .last_in            (req_last_point),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_slope     (rsp_line_slope),
      .rsp_line_intercept (rsp_line_intercept),
      .rsp_line_length    (rsp_line_length)
   );

   // Checks
   `SLSE_ASSERT_NEXT(a_accept_stalls, clock, reset, req_valid && !req_stall, req_stall, "request accepted but block not busy")
   `SLSE_ASSERT_IMPLY(a_emit_free, clock, reset, cmd.op == OP_EMIT, !rsp_valid, "result emitted over a pending result")
   `SLSE_ASSERT_IMPLY(a_idle_quiet, clock, reset, !req_stall, !status.div_busy && !status.sqrt_busy, "serial unit busy while idle")

endmodule
